[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the search unit's result stage.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

[design/wbps_pkg.sv]
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared types, constants and helpers of the wildcard byte pattern search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wbps_pkg;

   // window and pattern geometry
   localparam int PATTERN_BYTES = 16;
   localparam int LEN_W         = $clog2(PATTERN_BYTES + 1);
   localparam int IDX_W         = $clog2(PATTERN_BYTES);
   localparam int OFFSET_BITS   = 32;
   localparam int ADDR_W        = 64;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_INDEX_W   = 3;
   localparam int MASK_W        = 16;

   localparam logic [OFFSET_BITS-1:0] COUNT_MAX = {OFFSET_BITS{1'b1}};

   // configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LOW    = 3'd0,
      CSR_PATTERN_HIGH   = 3'd1,
      CSR_CARE_MASK      = 3'd2,
      CSR_PATTERN_LENGTH = 3'd3,
      CSR_REGION_BASE    = 3'd4
   } csr_index_type;

   // transaction held between the window row and the result stage
   typedef struct packed {
      logic                   valid;
      logic                   last;
      logic                   sat;
      logic [OFFSET_BITS-1:0] count;
   } stage_type;

   // pattern length in use: zero acts as one, clamp at the window depth
   function automatic logic [LEN_W-1:0] used_length(input logic [LEN_W-1:0] raw);
      logic [LEN_W-1:0] len;
      len = raw;
      if (raw == '0) begin
         len = LEN_W'(1);
      end else if (raw > LEN_W'(PATTERN_BYTES)) begin
         len = LEN_W'(PATTERN_BYTES);
      end
      return len;
   endfunction

endpackage

`default_nettype wire

[design/wbps_cell.sv]
// ----------------------------------------------------------------------------
// wbps_cell
// One window cell: holds one byte, passes it to the next cell on each shift
// and compares it with the pattern byte aligned to its position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wbps_cell (
   input  wire logic       clock,
   input  wire logic       shift_en,
   input  wire logic [7:0] shift_byte,
   input  wire logic [7:0] pat_byte,
   input  wire logic       compare_en,
   output logic      [7:0] byte_out,
   output logic            hit
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   // take the neighbor's byte on every accepted transaction
   assign byte_in = shift_en ? shift_byte : byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   // a position outside the pattern or a wildcard always hits
   assign hit      = !compare_en || (byte_ff == pat_byte);
   assign byte_out = byte_ff;

endmodule

`default_nettype wire

[design/wbps_result.sv]
// ----------------------------------------------------------------------------
// wbps_result
// Result stage: qualifies the window match, tracks the reported flag for the
// region and holds the result transaction until it is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module wbps_result (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire wbps_pkg::stage_type                 stage,
   input  wire logic                                window_hit,
   input  wire logic [wbps_pkg::LEN_W-1:0]          len,
   input  wire logic [wbps_pkg::ADDR_W-1:0]         region_base,
   output logic                                     free,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_found,
   output logic      [wbps_pkg::ADDR_W-1:0]         rsp_match_address
);

   import wbps_pkg::*;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   found_ff, found_in;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   logic                   reported_ff, reported_in;
   logic                   advance;
   logic                   long_enough;
   logic                   hit;
   logic                   emit;
   logic [OFFSET_BITS-1:0] offset;
   logic [ADDR_W-1:0]      address;

   // the stage moves on when the output register is empty or being drained
   assign free    = !rsp_valid_ff || rsp_ready;
   assign advance = stage.valid && free;

   // match start offset and address
   assign long_enough = stage.count >= OFFSET_BITS'(len);
   assign offset      = stage.count - OFFSET_BITS'(len);
   assign address     = region_base + ADDR_W'(offset);

   // first match inside the region, or the end of a region with none
   assign hit  = !reported_ff && !stage.sat && long_enough && window_hit;
   assign emit = !reported_ff && (hit || stage.last);

   // next state of the output register and the reported flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      found_in     = found_ff;
      addr_in      = addr_ff;
      reported_in  = reported_ff;
      if (advance) begin
         rsp_valid_in = emit;
         found_in     = hit;
         addr_in      = hit ? address : '0;
         reported_in  = stage.last ? 1'b0 : (reported_ff || hit);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         reported_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         reported_ff  <= reported_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff <= found_in;
      addr_ff  <= addr_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = found_ff;
   assign rsp_match_address = addr_ff;

   // a not-found result always carries a zero address
   `ASSERT_PROP(a_miss_zero_addr, clock, reset, (rsp_valid_ff && !found_ff) |-> (addr_ff == '0), "not-found result with nonzero address")
   // a match inside a region marks it as reported
   `ASSERT_PROP(a_hit_sets_flag, clock, reset, (advance && hit && !stage.last) |=> reported_ff, "match did not set reported flag")
   // the end of a region always clears the reported flag
   `ASSERT_PROP(a_last_clears_flag, clock, reset, (advance && stage.last) |=> !reported_ff, "reported flag survived end of region")
   // nothing is reported twice in a region
   `ASSERT_NEVER(a_no_second_hit, clock, reset, reported_ff && hit, "second match in one region")

endmodule

`default_nettype wire

[design/wildcard_byte_pattern_search_unit.sv]
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_search_unit
// Scans a region one byte per transaction through a row of window cells and
// reports the first masked pattern match, or a miss on the region's last byte.
// ----------------------------------------------------------------------------
// Pipeline: two register stages, the window stage and the result register; a
// byte's result enters the result register when the window stage advances.
// Throughput: one byte per cycle; a result waiting on rsp_ready lets one more
// byte into the window stage, then holds req_ready low until it is taken.
// Reset: configuration returns to its reset values, byte count, reported
// flag and both handshake stages are cleared; window bytes are not reset.
`timescale 1ns / 1ps
`default_nettype none

module wildcard_byte_pattern_search_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // input bytes
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [7:0]                           req_data_byte,
   input  wire logic                                 req_last_byte,
   // results
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_found,
   output logic      [wbps_pkg::ADDR_W-1:0]          rsp_match_address,
   // configuration writes
   input  wire logic                                 csr_write_enable,
   input  wire logic [wbps_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [wbps_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   import wbps_pkg::*;

   logic [63:0]       pattern_low_ff, pattern_low_in;
   logic [63:0]       pattern_high_ff, pattern_high_in;
   logic [MASK_W-1:0] care_mask_ff, care_mask_in;
   logic [LEN_W-1:0]  pattern_length_ff, pattern_length_in;
   logic [ADDR_W-1:0] region_base_ff, region_base_in;

   stage_type              stage_ff, stage_in;
   logic                   req_accept;
   logic                   free;
   logic [OFFSET_BITS-1:0] base_count;
   logic                   base_sat;
   logic [LEN_W-1:0]       len;
   logic [7:0]             pat_bytes [PATTERN_BYTES];
   logic [7:0]             cell_bytes [PATTERN_BYTES];
   logic [PATTERN_BYTES-1:0] cell_hits;

   // configuration registers
   always_comb begin
      pattern_low_in    = pattern_low_ff;
      pattern_high_in   = pattern_high_ff;
      care_mask_in      = care_mask_ff;
      pattern_length_in = pattern_length_ff;
      region_base_in    = region_base_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_PATTERN_LOW:    pattern_low_in    = csr_write_data;
            CSR_PATTERN_HIGH:   pattern_high_in   = csr_write_data;
            CSR_CARE_MASK:      care_mask_in      = csr_write_data[MASK_W-1:0];
            CSR_PATTERN_LENGTH: pattern_length_in = csr_write_data[LEN_W-1:0];
            CSR_REGION_BASE:    region_base_in    = csr_write_data;
            default:            ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         care_mask_ff      <= {MASK_W{1'b1}};
         pattern_length_ff <= LEN_W'(1);
         region_base_ff    <= '0;
      end else begin
         pattern_low_ff    <= pattern_low_in;
         pattern_high_ff   <= pattern_high_in;
         care_mask_ff      <= care_mask_in;
         pattern_length_ff <= pattern_length_in;
         region_base_ff    <= region_base_in;
      end
   end

   assign len = used_length(pattern_length_ff);

   // pattern register viewed as bytes
   always_comb begin
      for (int i = 0; i < PATTERN_BYTES; i++) begin
         if (i < 8) begin
            pat_bytes[i] = pattern_low_ff[8*i +: 8];
         end else begin
            pat_bytes[i] = pattern_high_ff[8*(i-8) +: 8];
         end
      end
   end

   // input handshake: take a byte when the window stage is empty or moving
   assign req_ready  = !stage_ff.valid || free;
   assign req_accept = req_valid && req_ready;

   // byte count restarts after the last byte of a region and saturates
   assign base_count = stage_ff.last ? '0 : stage_ff.count;
   assign base_sat   = (base_count == COUNT_MAX);

   always_comb begin
      stage_in = stage_ff;
      if (req_accept) begin
         stage_in.valid = 1'b1;
         stage_in.last  = req_last_byte;
         stage_in.sat   = base_sat;
         stage_in.count = base_sat ? base_count : base_count + OFFSET_BITS'(1);
      end else if (free) begin
         stage_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   // row of window cells, cell k holds the byte taken k transactions ago
   for (genvar k = 0; k < PATTERN_BYTES; k++) begin : g_cell
      logic [LEN_W-1:0] pat_idx;
      logic             active;
      logic [7:0]       shift_byte;

      assign active     = len > LEN_W'(k);
      assign pat_idx    = len - LEN_W'(k) - LEN_W'(1);
      assign shift_byte = (k == 0) ? req_data_byte : cell_bytes[(k == 0) ? 0 : k - 1];

      wbps_cell u_cell (
         .clock      (clock),
         .shift_en   (req_accept),
         .shift_byte (shift_byte),
         .pat_byte   (pat_bytes[pat_idx[IDX_W-1:0]]),
         .compare_en (active && care_mask_ff[pat_idx[IDX_W-1:0]]),
         .byte_out   (cell_bytes[k]),
         .hit        (cell_hits[k])
      );
   end

   // result stage
   wbps_result u_result (
      .clock             (clock),
      .reset             (reset),
      .stage             (stage_ff),
      .window_hit        (&cell_hits),
      .len               (len),
      .region_base       (region_base_ff),
      .free              (free),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_match_address (rsp_match_address)
   );

endmodule

`default_nettype wire
